// ===== design/ufp_pkg.sv =====
package ufp_pkg;

   localparam int BYTE_W   = 8;
   localparam int PHASE_W  = 3;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 9;
   localparam int LEN_W    = 16;
   localparam int CFG_W    = 10;

   // largest payload the parser will take, whatever the register says
   localparam int PAYLOAD_DEPTH = 512;
   localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);

   localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(512);
   localparam logic [BYTE_W-1:0] SYNC1     = 8'hB5;
   localparam logic [BYTE_W-1:0] SYNC2     = 8'h62;

   localparam logic [PHASE_W-1:0] PH_SYNC1   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SYNC2   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_CLASS   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_ID      = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LEN     = 3'd4;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd5;
   localparam logic [PHASE_W-1:0] PH_CK      = 3'd6;

   localparam logic [STATUS_W-1:0] ST_BUSY = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DATA = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OK   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LONG = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LOST = 3'd5;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   payload_data;
      logic [POS_W-1:0]    payload_pos;
      logic [BYTE_W-1:0]   frame_class;
      logic [BYTE_W-1:0]   frame_id;
      logic [LEN_W-1:0]    frame_len;
   } rsp_type;

endpackage

// ===== design/ubx_frame_parser_core.sv =====
// UBX frame parser. One received serial byte enters on the req_ channel per
// word; every byte yields exactly one rsp_ word carrying a status code (busy,
// payload byte, frame ok, checksum bad, length too long, sync lost), the
// payload byte and its index when status is payload, and the class, id and
// declared length of the current frame.
// Pipeline: an input register, the parser step, and a result register. A
// byte accepted into the input register passes through the parser step into
// the result register and from there onto rsp_, and a byte can be accepted
// every cycle while rsp_stall is low: sustained rate is one byte per cycle,
// as the parser state updates once per accepted byte.
// When rsp_stall is high with a result waiting, the parser holds and the
// input register keeps one more byte; req_stall then rises until the result
// is taken. No word is dropped or duplicated.
// csr_ writes the payload length limit (10 bits); csr_ready is always high.
// The limit in effect is the smaller of that register and 512.
// Synchronous reset empties both registers, returns the parser to the sync
// hunt with sums and frame fields cleared, and sets the limit to 512.
module ubx_frame_parser_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ufp_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ufp_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ufp_pkg::BYTE_W-1:0]      rsp_payload_data,
   output logic [ufp_pkg::POS_W-1:0]       rsp_payload_pos,
   output logic [ufp_pkg::BYTE_W-1:0]      rsp_frame_class,
   output logic [ufp_pkg::BYTE_W-1:0]      rsp_frame_id,
   output logic [ufp_pkg::LEN_W-1:0]       rsp_frame_len,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ufp_pkg::CFG_W-1:0]       csr_max_payload_len
);

   logic                        in_valid_ff, in_valid_in;
   logic [ufp_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                        out_valid_ff, out_valid_in;
   ufp_pkg::rsp_type            out_ff;
   ufp_pkg::rsp_type            step_result;
   logic [ufp_pkg::CFG_W-1:0]   max_len_ff;
   logic                        fire;
   logic                        req_take;
   logic                        rsp_take;

   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_take);

   ufp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (in_byte_ff),
      .max_len (max_len_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_len_ff   <= ufp_pkg::CFG_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_max_payload_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (fire) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_payload_data = out_ff.payload_data;
   assign rsp_payload_pos  = out_ff.payload_pos;
   assign rsp_frame_class  = out_ff.frame_class;
   assign rsp_frame_id     = out_ff.frame_id;
   assign rsp_frame_len    = out_ff.frame_len;

endmodule

// ===== design/ufp_parse.sv =====
module ufp_parse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [ufp_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [ufp_pkg::CFG_W-1:0]     max_len,
   output ufp_pkg::rsp_type              result
);

   localparam logic [ufp_pkg::LEN_W-1:0] DEPTH_LEN = ufp_pkg::LEN_W'(ufp_pkg::PAYLOAD_DEPTH);

   logic [ufp_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [ufp_pkg::BYTE_W-1:0]  sum_a_ff, sum_a_in;
   logic [ufp_pkg::BYTE_W-1:0]  sum_b_ff, sum_b_in;
   logic [ufp_pkg::BYTE_W-1:0]  len_low_ff, len_low_in;
   logic [ufp_pkg::LEN_W-1:0]   length_ff, length_in;
   logic [ufp_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [ufp_pkg::BYTE_W-1:0]  class_ff, class_in;
   logic [ufp_pkg::BYTE_W-1:0]  id_ff, id_in;
   logic                        sub_ff, sub_in;

   logic [ufp_pkg::BYTE_W-1:0]   sum_a_add, sum_b_add;
   logic [ufp_pkg::LEN_W-1:0]    limit;
   logic [ufp_pkg::CNT_W-1:0]    count_inc;
   logic [ufp_pkg::STATUS_W-1:0] status;
   logic [ufp_pkg::BYTE_W-1:0]   data;
   logic [ufp_pkg::POS_W-1:0]    pos;

   // Fletcher running sums with this byte added
   assign sum_a_add = sum_a_ff + rx_byte;
   assign sum_b_add = sum_b_ff + sum_a_add;
   assign count_inc = count_ff + ufp_pkg::CNT_W'(1);
   assign limit     = (ufp_pkg::LEN_W'(max_len) > DEPTH_LEN) ? DEPTH_LEN
                                                             : ufp_pkg::LEN_W'(max_len);

   always_comb begin
      phase_in   = phase_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      len_low_in = len_low_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      class_in   = class_ff;
      id_in      = id_ff;
      sub_in     = sub_ff;
      status     = ufp_pkg::ST_BUSY;
      data       = '0;
      pos        = '0;
      unique case (phase_ff)
         ufp_pkg::PH_SYNC2: begin
            if (rx_byte == ufp_pkg::SYNC2) begin
               phase_in = ufp_pkg::PH_CLASS;
            end else begin
               phase_in = ufp_pkg::PH_SYNC1;
               status   = ufp_pkg::ST_LOST;
            end
         end
         ufp_pkg::PH_CLASS: begin
            // sums restart at the class byte
            sum_a_in  = rx_byte;
            sum_b_in  = rx_byte;
            length_in = '0;
            class_in  = rx_byte;
            phase_in  = ufp_pkg::PH_ID;
         end
         ufp_pkg::PH_ID: begin
            id_in    = rx_byte;
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            sub_in   = 1'b0;
            phase_in = ufp_pkg::PH_LEN;
         end
         ufp_pkg::PH_LEN: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            if (!sub_ff) begin
               len_low_in = rx_byte;
               sub_in     = 1'b1;
            end else begin
               sub_in    = 1'b0;
               length_in = {rx_byte, len_low_ff};
               count_in  = '0;
               if (length_in > limit) begin
                  status   = ufp_pkg::ST_LONG;
                  phase_in = ufp_pkg::PH_SYNC1;
               end else if (length_in == '0) begin
                  phase_in = ufp_pkg::PH_CK;
               end else begin
                  phase_in = ufp_pkg::PH_PAYLOAD;
               end
            end
         end
         ufp_pkg::PH_PAYLOAD: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            status   = ufp_pkg::ST_DATA;
            data     = rx_byte;
            pos      = count_ff[ufp_pkg::POS_W-1:0];
            if (ufp_pkg::LEN_W'(count_inc) >= length_ff) begin
               count_in = '0;
               sub_in   = 1'b0;
               phase_in = ufp_pkg::PH_CK;
            end else begin
               count_in = count_inc;
            end
         end
         ufp_pkg::PH_CK: begin
            if (!sub_ff) begin
               if (rx_byte == sum_a_ff) begin
                  sub_in = 1'b1;
               end else begin
                  status   = ufp_pkg::ST_BAD;
                  phase_in = ufp_pkg::PH_SYNC1;
               end
            end else begin
               sub_in   = 1'b0;
               status   = (rx_byte == sum_b_ff) ? ufp_pkg::ST_OK : ufp_pkg::ST_BAD;
               phase_in = ufp_pkg::PH_SYNC1;
            end
         end
         default: begin
            // hunt, also taken for the unused code
            phase_in = (rx_byte == ufp_pkg::SYNC1) ? ufp_pkg::PH_SYNC2 : ufp_pkg::PH_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ufp_pkg::PH_SYNC1;
         sum_a_ff   <= '0;
         sum_b_ff   <= '0;
         len_low_ff <= '0;
         length_ff  <= '0;
         count_ff   <= '0;
         class_ff   <= '0;
         id_ff      <= '0;
         sub_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         sum_a_ff   <= sum_a_in;
         sum_b_ff   <= sum_b_in;
         len_low_ff <= len_low_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         class_ff   <= class_in;
         id_ff      <= id_in;
         sub_ff     <= sub_in;
      end
   end

   assign result.status       = status;
   assign result.payload_data = data;
   assign result.payload_pos  = pos;
   assign result.frame_class  = class_in;
   assign result.frame_id     = id_in;
   assign result.frame_len    = length_in;

   a_payload_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == ufp_pkg::PH_PAYLOAD |-> length_ff != '0)
      else $error("payload phase with zero length");

   a_count_below_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == ufp_pkg::PH_PAYLOAD |-> ufp_pkg::LEN_W'(count_ff) < length_ff)
      else $error("payload counter ran past frame length");

   a_len_within_depth: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ufp_pkg::PH_PAYLOAD || phase_ff == ufp_pkg::PH_CK)
      |-> length_ff <= DEPTH_LEN)
      else $error("accepted frame longer than payload depth");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !reset && !fire |=> $stable(phase_ff) && $stable(sum_a_ff) && $stable(sum_b_ff))
      else $error("parser state moved without a word");

endmodule
